[design/fdt_pkg.sv]
// Shared constants, types and the FNV-1a byte fold for the hash dedup table.
package fdt_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// Hash queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Field widths
	localparam int HASH_W = 64;
	localparam int OUT_IDX_W = 6;
	localparam int OUT_DATA_W = 72;

	// FNV-1a 64-bit constants
	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [HASH_W-1:0] FNV_PRIME = 64'h0000_0100_0000_01B3;

	// Word pushed into the hash queue
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
	} q_wr_t;

	// Head of the hash queue
	typedef struct packed {
		logic              valid;
		logic [HASH_W-1:0] hash;
	} q_rd_t;

	// One lookup result
	typedef struct packed {
		logic                 hit;
		logic [OUT_IDX_W-1:0] entry_index;
		logic [HASH_W-1:0]    hash_value;
		logic                 table_full;
	} res_t;

	// Xor the byte in, then multiply by the prime (2^40 + 0x1B3) as shifted adds
	function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
		input logic [7:0] b);
		logic [HASH_W-1:0] x;
		x = h ^ {{(HASH_W-8){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

[design/fnv1a_dedup_table_top.sv]
// Top level of the FNV-1a 64-bit hash dedup table.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   s_tvalid/s_tready  s_tdata[7:0] data_byte, s_tlast last_byte
//  m_*       out  m_tvalid/m_tready  m_tdata: hit, entry_index, hash_value, table_full
//
// Bytes are hashed at one per cycle; the hash loop is a single xor and
// shift-add multiply by the FNV prime in the front end.
// The table search for a buffer compares the N stored entries in order, one entry
// per cycle through the single read port, and stops at the first hit.
// Up to four final hashes wait in the queue, so a search overlaps the hashing
// of following buffers; s_tready falls only while that queue is full.
// Reset clears the running hash to the offset basis and empties the table.
module fnv1a_dedup_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [0] hit, [6:1] entry_index, [70:7] hash_value,
	                               // [71] table_full
);
	import fdt_pkg::*;

	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  q_full;
	logic  pop;
	res_t  res;

	fdt_hasher u_hasher (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.q_full  (q_full),
		.q_wr    (q_wr)
	);

	fdt_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.q_wr  (q_wr),
		.q_full(q_full),
		.pop   (pop),
		.q_rd  (q_rd)
	);

	fdt_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_rd    (q_rd),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_res   (res)
	);

	// Pack the result word, hit in the lowest bit and table_full in the top bit
	assign m_tdata = {res.table_full, res.hash_value, res.entry_index, res.hit};

	// A hit and a full table never come together
	a_hit_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res.hit && res.table_full))
		else $error("hit and table_full both set");

	// A full-table result carries index zero
	a_full_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && res.table_full) |-> (res.entry_index == '0))
		else $error("table_full with nonzero entry_index");

	// The front end never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.valid |-> !q_full)
		else $error("hash queue overflow");

	// A pop only happens with a word waiting
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_rd.valid)
		else $error("hash queue underflow");

endmodule

[design/fdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fdt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[design/fdt_hasher.sv]
// Front end: folds incoming bytes into the running hash and queues final hashes.
module fdt_hasher (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,   // [7:0] data_byte
	input  logic          s_tlast,   // last_byte
	input  logic          q_full,
	output fdt_pkg::q_wr_t q_wr
);
	import fdt_pkg::*;

	logic [HASH_W-1:0] run_q;
	logic [HASH_W-1:0] h_next;
	logic              take;

	// Accept a byte whenever the queue can take a final hash
	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;
	assign h_next   = fold_byte(run_q, s_tdata);

	// Push the final hash on the last byte of a buffer
	assign q_wr.valid = take && s_tlast;
	assign q_wr.hash  = h_next;

	// Advance the running hash, reload the basis after a last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= FNV_BASIS;
		end else if (take) begin
			run_q <= s_tlast ? FNV_BASIS : h_next;
		end
	end

endmodule

[design/fdt_queue.sv]
// Small FIFO of final hashes between the hashing front and the table back end.
module fdt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  fdt_pkg::q_wr_t q_wr,
	output logic           q_full,
	input  logic           pop,
	output fdt_pkg::q_rd_t q_rd
);
	import fdt_pkg::*;

	logic [HASH_W-1:0] slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign q_full     = (cnt_q == QCNT_W'(QDEPTH));
	assign q_rd.valid = (cnt_q != '0);
	assign q_rd.hash  = slot_q[rd_ptr_q];
	assign do_pop     = pop && q_rd.valid;

	// Store pushed hashes
	always_ff @(posedge clk) begin
		if (q_wr.valid) begin
			slot_q[wr_ptr_q] <= q_wr.hash;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (q_wr.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({q_wr.valid, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/fdt_search.sv]
// Back end: scans the stored hashes, appends new ones and drives the result word.
module fdt_search (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fdt_pkg::q_rd_t        q_rd,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output fdt_pkg::res_t         m_res
);
	import fdt_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_MISS, ST_DONE} state_t;

	state_t            state_q;
	logic [HASH_W-1:0] cur_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  scan_next;
	res_t              res_q;
	logic              table_has_room;
	logic              wr_en;
	logic [IDX_W-1:0]  rd_addr;
	logic [HASH_W-1:0] rd_data;
	logic              out_free;

	// Pick up the next hash only when idle
	assign pop            = (state_q == ST_IDLE) && q_rd.valid;
	assign scan_next      = scan_q + CNT_W'(1);
	assign table_has_room = (count_q != CNT_W'(TABLE_DEPTH));
	assign wr_en          = (state_q == ST_MISS) && table_has_room;
	assign out_free       = !m_tvalid || m_tready;

	// Read entry zero on pickup, then the entry after the one being compared
	assign rd_addr = (state_q == ST_IDLE) ? '0 : scan_next[IDX_W-1:0];

	fdt_ram #(
		.WIDTH(HASH_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(cur_q),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Search sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			scan_q   <= '0;
			m_tvalid <= 1'b0;
			cur_q    <= '0;
			res_q    <= '0;
			m_res    <= '0;
		end else begin
			// Raise valid on handoff, drop it once the word is taken
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_rd.valid) begin
						cur_q   <= q_rd.hash;
						scan_q  <= '0;
						state_q <= (count_q == '0) ? ST_MISS : ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Compare entry scan_q; first match wins
					if (rd_data == cur_q) begin
						res_q.hit         <= 1'b1;
						res_q.entry_index <= OUT_IDX_W'({{OUT_IDX_W{1'b0}},
							scan_q[IDX_W-1:0]});
						res_q.hash_value  <= cur_q;
						res_q.table_full  <= 1'b0;
						state_q           <= ST_DONE;
					end else if (scan_next == count_q) begin
						state_q <= ST_MISS;
					end else begin
						scan_q <= scan_next;
					end
				end
				ST_MISS: begin
					// Append at the next free entry, or flag the table full
					res_q.hit        <= 1'b0;
					res_q.hash_value <= cur_q;
					if (table_has_room) begin
						res_q.entry_index <= OUT_IDX_W'({{OUT_IDX_W{1'b0}},
							count_q[IDX_W-1:0]});
						res_q.table_full  <= 1'b0;
						count_q           <= count_q + CNT_W'(1);
					end else begin
						res_q.entry_index <= '0;
						res_q.table_full  <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// Hand the result over once the output register is free
					if (out_free) begin
						m_res   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sim/fdt_lookup_checker.sv]
// Checker for the FNV-1a dedup table: predicts each lookup from the input words and compares.
`timescale 1ns / 100ps

module fdt_lookup_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,   // [0] hit, [6:1] entry_index, [70:7] hash_value,
	                               // [71] table_full
	output int          mismatches,
	output int          lookups_pending
);

	localparam int          DEPTH       = fdt_pkg::TABLE_DEPTH;
	localparam logic [63:0] HASH_BASIS  = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] HASH_PRIME  = 64'h0000_0100_0000_01B3;
	localparam int          REPORT_MAX  = 10;

	typedef struct packed {
		logic        hit;
		logic [5:0]  index;
		logic [63:0] hash;
		logic        full;
	} lookup_t;

	logic [63:0] buf_hash;
	logic [63:0] seen_hashes [DEPTH];
	int          seen_count;
	lookup_t     expected_lookups [$];
	lookup_t     want;
	lookup_t     got;
	logic [63:0] folded;
	logic        found;
	int          reported;
	int          i;

	initial begin
		mismatches      = 0;
		lookups_pending = 0;
		reported        = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_hash   = HASH_BASIS;
			seen_count = 0;
			expected_lookups.delete();
		end else begin
			// Compare an accepted result word with the oldest prediction
			if (m_tvalid && m_tready) begin
				got.hit   = m_tdata[0];
				got.index = m_tdata[6:1];
				got.hash  = m_tdata[70:7];
				got.full  = m_tdata[71];
				if (expected_lookups.size() == 0) begin
					mismatches++;
					if (reported < REPORT_MAX) begin
						reported++;
						$display("%0t: result with nothing pending: hit=%0d index=%0d hash=%h full=%0d",
							$time, got.hit, got.index, got.hash, got.full);
					end
				end else begin
					want = expected_lookups.pop_front();
					if (got.hit !== want.hit || got.index !== want.index ||
						got.hash !== want.hash || got.full !== want.full) begin
						mismatches++;
						if (reported < REPORT_MAX) begin
							reported++;
							$display("%0t: lookup mismatch: expected hit=%0d index=%0d hash=%h full=%0d",
								$time, want.hit, want.index, want.hash, want.full);
							$display("%0t:                  actual hit=%0d index=%0d hash=%h full=%0d",
								$time, got.hit, got.index, got.hash, got.full);
						end
					end
				end
			end

			// Fold an accepted byte; on the last byte resolve the table lookup
			if (s_tvalid && s_tready) begin
				folded = (buf_hash ^ {56'd0, s_tdata}) * HASH_PRIME;
				if (!s_tlast) begin
					buf_hash = folded;
				end else begin
					buf_hash   = HASH_BASIS;
					want       = '0;
					want.hash  = folded;
					found      = 1'b0;
					for (i = 0; i < seen_count; i++) begin
						if (!found && seen_hashes[i] == folded) begin
							found     = 1'b1;
							want.hit  = 1'b1;
							want.index = 6'(i);
						end
					end
					if (!found) begin
						if (seen_count < DEPTH) begin
							seen_hashes[seen_count] = folded;
							want.index = 6'(seen_count);
							seen_count++;
						end else begin
							want.full = 1'b1;
						end
					end
					expected_lookups.push_back(want);
				end
			end
			lookups_pending = expected_lookups.size();
		end
	end

endmodule

[sim/tb.sv]
// Testbench top for the FNV-1a dedup table: byte stimulus, result drain and verdict.
`timescale 1ns / 100ps

module tb;

	localparam int ITEM_TARGET  = 450;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 8;
	localparam int TAIL_CYCLES  = 120;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	int          mismatches;
	int          lookups_pending;

	// Bytes of every distinct buffer sent, for replays that should hit
	logic [7:0]  buf_bytes [$];
	int          buf_start [$];
	int          buf_len [$];
	int          bytes_sent;
	logic        send_burst;
	logic        drain_burst;
	int          words_drained;

	fnv1a_dedup_table_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	fdt_lookup_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.mismatches      (mismatches),
		.lookups_pending (lookups_pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Offer one byte, after a random gap unless in a burst, and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	// Send a buffer held in the tail of the byte history and record it
	task automatic send_recorded(input int len);
		int start;
		int k;
		start = buf_bytes.size() - len;
		buf_start.push_back(start);
		buf_len.push_back(len);
		for (k = 0; k < len; k++)
			send_byte(buf_bytes[start + k], k == len - 1);
	endtask

	// Resend an earlier buffer so its hash is already stored
	task automatic send_replay(input int which);
		int k;
		for (k = 0; k < buf_len[which]; k++)
			send_byte(buf_bytes[buf_start[which] + k], k == buf_len[which] - 1);
	endtask

	task automatic send_random_buffer(input int len);
		int k;
		for (k = 0; k < len; k++)
			buf_bytes.push_back(8'($urandom_range(0, 255)));
		send_recorded(len);
	endtask

	// Drain results with random stalls and one long hold-off
	initial begin
		int stall;
		m_tready      = 1'b0;
		drain_burst   = 1'b0;
		words_drained = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0)
				drain_burst = ~drain_burst;
			stall = drain_burst ? 0 : $urandom_range(0, 11);
			if (words_drained == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			words_drained++;
		end
	end

	// Reset, directed buffers, random buffers, then drain and verdict
	initial begin
		int len;
		s_tvalid   = 1'b0;
		s_tdata    = 8'd0;
		s_tlast    = 1'b0;
		send_burst = 1'b0;
		bytes_sent = 0;
		arst_n     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extreme single-byte buffers, then a repeat that must hit
		buf_bytes.push_back(8'h00);
		send_recorded(1);
		buf_bytes.push_back(8'hFF);
		send_recorded(1);
		send_replay(0);
		// Multi-byte buffer with unmarked bytes, then its repeat
		buf_bytes.push_back(8'hFF);
		buf_bytes.push_back(8'h00);
		buf_bytes.push_back(8'h55);
		buf_bytes.push_back(8'hAA);
		send_recorded(4);
		send_replay(2);
		// Zero bytes only, differs from the single zero byte
		repeat (4) buf_bytes.push_back(8'h00);
		send_recorded(4);
		send_replay(1);

		// Random buffers: mostly short, some long, a share of replays
		while (bytes_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 4) == 0)
				send_burst = ~send_burst;
			if ($urandom_range(0, 99) < 35) begin
				send_replay($urandom_range(0, buf_len.size() - 1));
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
				send_random_buffer(len);
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);

		// Wait for every lookup, then let the pipeline settle
		while (lookups_pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && lookups_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
